// File: rtl/swfe_pkg.sv
// Shared types and constants for the sync-word frame extractor.
// Depends on nothing; every other file of the block uses it.
`default_nettype none

package swfe_pkg;

   localparam int HEADER_BYTES_DEFAULT = 12;

   localparam int BYTE_BITS   = 8;
   localparam int SYNC_BITS   = 32;
   localparam int DIR_BITS    = 16;
   localparam int COORD_BITS  = 8;
   localparam int LEN_BITS    = 32;
   localparam int PICNUM_BITS = 16;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SYNC_WORD      = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIRECTION_WORD = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COORD_BLOCK    = 2'd2;

   localparam logic [SYNC_BITS-1:0]  SYNC_WORD_RESET      = 32'h55BB_10A1;
   localparam logic [DIR_BITS-1:0]   DIRECTION_WORD_RESET = 16'h01B1;
   localparam logic [COORD_BITS-1:0] COORD_BLOCK_RESET    = 8'd64;

   typedef struct packed {
      logic [SYNC_BITS-1:0]  sync_word;
      logic [DIR_BITS-1:0]   direction_word;
      logic [COORD_BITS-1:0] coord_block_len;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0]   pic_byte;
      logic                   pic_last;
      logic [PICNUM_BITS-1:0] pic_number;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/swfe_if.sv
// Valid/ready channel interfaces for request, response and register writes.
// Depends on swfe_pkg for field widths.
`default_nettype none

interface swfe_req_if;
   logic                            valid;
   logic                            ready;
   logic [swfe_pkg::BYTE_BITS-1:0]  in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface swfe_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [swfe_pkg::BYTE_BITS-1:0]    pic_byte;
   logic                              pic_last;
   logic [swfe_pkg::PICNUM_BITS-1:0]  pic_number;

   modport source (output valid, output pic_byte, output pic_last, output pic_number,
                   input ready);
   modport sink   (input valid, input pic_byte, input pic_last, input pic_number,
                   output ready);
endinterface

interface swfe_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [swfe_pkg::CSR_INDEX_BITS-1:0]  index;
   logic [swfe_pkg::CSR_DATA_BITS-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/sync_word_frame_extractor.sv
// Top level of the sync-word frame extractor: registers, core and output stage.
// Depends on swfe_pkg, swfe_if, swfe_csr, swfe_core and swfe_out_stage.
`default_nettype none

// Takes one stream byte per cycle while req_ch.ready is high and gives at most
// one picture byte for it in the next cycle, through a single output register.
// The header compare against the sliding window, the length subtract and the
// counters all settle between the input transfer and the output register, and
// req_ch.ready is low only while a held response is not taken. Header bytes and
// coordinate bytes give no response; pic_last marks the final byte of a picture
// and pic_number wraps at 65536. Register writes are always ready.
module sync_word_frame_extractor #(
   parameter int HEADER_BYTES = swfe_pkg::HEADER_BYTES_DEFAULT
) (
   input  wire          clock,
   input  wire          reset,
   swfe_req_if.sink     req_ch,
   swfe_rsp_if.source   rsp_ch,
   swfe_csr_if.sink     csr_ch
);

   swfe_pkg::cfg_type      cfg;
   swfe_pkg::result_type   res;
   swfe_pkg::result_type   out_data;
   logic                   res_valid;
   logic                   in_ready;
   logic                   accept;

   assign accept       = req_ch.valid && in_ready;
   assign req_ch.ready = in_ready;

   swfe_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_ch.valid),
      .wr_ready (csr_ch.ready),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   swfe_core #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .in_byte   (req_ch.in_byte),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   swfe_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .res_valid (res_valid),
      .res       (res),
      .in_ready  (in_ready),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_data)
   );

   assign rsp_ch.pic_byte   = out_data.pic_byte;
   assign rsp_ch.pic_last   = out_data.pic_last;
   assign rsp_ch.pic_number = out_data.pic_number;

endmodule

`default_nettype wire

// File: rtl/swfe_csr.sv
// Configuration registers: sync word, direction word, coordinate block size.
// Depends on swfe_pkg for indexes, widths and reset values.
`default_nettype none

module swfe_csr (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   wr_valid,
   output logic                                  wr_ready,
   input  wire  [swfe_pkg::CSR_INDEX_BITS-1:0]   wr_index,
   input  wire  [swfe_pkg::CSR_DATA_BITS-1:0]    wr_data,
   output swfe_pkg::cfg_type                     cfg
);

   swfe_pkg::cfg_type cfg_ff;
   swfe_pkg::cfg_type cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         unique case (wr_index)
            swfe_pkg::CSR_SYNC_WORD: begin
               cfg_in.sync_word = wr_data[swfe_pkg::SYNC_BITS-1:0];
            end
            swfe_pkg::CSR_DIRECTION_WORD: begin
               cfg_in.direction_word = wr_data[swfe_pkg::DIR_BITS-1:0];
            end
            swfe_pkg::CSR_COORD_BLOCK: begin
               cfg_in.coord_block_len = wr_data[swfe_pkg::COORD_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_word       <= swfe_pkg::SYNC_WORD_RESET;
         cfg_ff.direction_word  <= swfe_pkg::DIRECTION_WORD_RESET;
         cfg_ff.coord_block_len <= swfe_pkg::COORD_BLOCK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/swfe_core.sv
// Header hunt, coordinate skip and payload counting, one byte per transfer.
// Depends on swfe_pkg for the configuration and result types.
`default_nettype none

module swfe_core #(
   parameter int HEADER_BYTES = swfe_pkg::HEADER_BYTES_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                accept,
   input  wire  [swfe_pkg::BYTE_BITS-1:0]     in_byte,
   input  swfe_pkg::cfg_type                  cfg,
   output logic                               res_valid,
   output swfe_pkg::result_type               res
);

   localparam int FILL_BITS = $clog2(HEADER_BYTES + 1);
   localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(HEADER_BYTES);
   localparam logic [FILL_BITS-1:0] FILL_ALMOST = FILL_BITS'(HEADER_BYTES - 1);

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_SKIP    = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   phase_type                          phase_ff, phase_in;
   logic [swfe_pkg::BYTE_BITS-1:0]     win_ff [HEADER_BYTES];
   logic [swfe_pkg::BYTE_BITS-1:0]     win_in [HEADER_BYTES];
   logic [FILL_BITS-1:0]               fill_ff, fill_in;
   logic [swfe_pkg::LEN_BITS-1:0]      left_ff, left_in;
   logic [swfe_pkg::COORD_BITS-1:0]    coord_ff, coord_in;
   logic [swfe_pkg::PICNUM_BITS-1:0]   count_ff, count_in;

   logic                               full_next;
   logic                               match;
   logic [swfe_pkg::LEN_BITS-1:0]      frame_len;
   logic [swfe_pkg::LEN_BITS-1:0]      coord_wide;
   logic [swfe_pkg::COORD_BITS-1:0]    coord_dec;
   logic                               last;

   always_comb begin
      for (int i = 0; i < HEADER_BYTES - 1; i++) begin
         win_in[i] = win_ff[i+1];
      end
      win_in[HEADER_BYTES-1] = in_byte;
   end

   assign full_next  = (fill_ff == FILL_FULL) || (fill_ff == FILL_ALMOST);
   assign match      = full_next
                       && ({win_in[3], win_in[2], win_in[1], win_in[0]} == cfg.sync_word)
                       && ({win_in[11], win_in[10]} == cfg.direction_word);
   assign frame_len  = {win_in[7], win_in[6], win_in[5], win_in[4]};
   assign coord_wide = {{(swfe_pkg::LEN_BITS-swfe_pkg::COORD_BITS){1'b0}},
                        cfg.coord_block_len};
   assign coord_dec  = (coord_ff != '0) ? coord_ff - 1'b1 : coord_ff;
   assign last       = (left_ff <= swfe_pkg::LEN_BITS'(1));

   always_comb begin
      phase_in       = phase_ff;
      fill_in        = fill_ff;
      left_in        = left_ff;
      coord_in       = coord_ff;
      count_in       = count_ff;
      res_valid      = 1'b0;
      res.pic_byte   = in_byte;
      res.pic_last   = last;
      res.pic_number = count_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_SKIP: begin
               coord_in = coord_dec;
               if (coord_dec == '0) begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               res_valid = 1'b1;
               if (last) begin
                  left_in  = '0;
                  count_in = count_ff + 1'b1;
                  phase_in = PH_HUNT;
                  fill_in  = '0;
               end else begin
                  left_in = left_ff - 1'b1;
               end
            end
            default: begin
               phase_in = PH_HUNT;
               fill_in  = (fill_ff == FILL_FULL) ? fill_ff : fill_ff + 1'b1;
               if (match) begin
                  fill_in = '0;
                  if (frame_len > coord_wide) begin
                     left_in  = frame_len - coord_wide;
                     coord_in = cfg.coord_block_len;
                     phase_in = (cfg.coord_block_len != '0) ? PH_SKIP : PH_PAYLOAD;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         fill_ff  <= '0;
         left_ff  <= '0;
         coord_ff <= '0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
         left_ff  <= left_in;
         coord_ff <= coord_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (phase_ff != PH_SKIP) && (phase_ff != PH_PAYLOAD)) begin
         win_ff <= win_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/swfe_out_stage.sv
// Output register between the core and the response channel.
// Depends on swfe_pkg for the result type.
`default_nettype none

module swfe_out_stage (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    load,
   input  wire                    res_valid,
   input  swfe_pkg::result_type   res,
   output logic                   in_ready,
   output logic                   out_valid,
   input  wire                    out_ready,
   output swfe_pkg::result_type   out_data
);

   logic                   valid_ff, valid_in;
   swfe_pkg::result_type   data_ff, data_in;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = res_valid;
         data_in  = res;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

`default_nettype wire

// File: rtl/swfe_checker.sv
// Port-level checks for the sync-word frame extractor, bound to its top level.
// Depends on swfe_pkg for field widths.
`default_nettype none

module swfe_checker (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_ready,
   input  wire                                rsp_valid,
   input  wire                                rsp_ready,
   input  wire  [swfe_pkg::BYTE_BITS-1:0]     pic_byte,
   input  wire                                pic_last,
   input  wire  [swfe_pkg::PICNUM_BITS-1:0]   pic_number
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("response without a request transfer");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pic_byte) && $stable(pic_last)
                                  && $stable(pic_number))
      else $error("stalled response changed");

endmodule

bind sync_word_frame_extractor swfe_checker u_swfe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .pic_byte   (rsp_ch.pic_byte),
   .pic_last   (rsp_ch.pic_last),
   .pic_number (rsp_ch.pic_number)
);

`default_nettype wire
